// ===== rtl/qphi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphi_pkg
// Shared types, constants and helpers for the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qphi_pkg;

    // field widths of the ports
    localparam int KEY_W   = 31;
    localparam int SLOT_W  = 10;
    localparam int SIZE_W  = 11;
    localparam int PROBE_W = 11;

    // default geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 31;

    // size register after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_HOME    = 2'd0,
        ST_PROBED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    // control sequencer states
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_HCHK,
        S_PCHK,
        S_RDATA,
        S_EMIT
    } t_state;

    // (a + b) mod n for a + b < 2n
    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        return s[SIZE_W-1:0];
    endfunction

endpackage

// ===== rtl/qphi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphi_ram
// Single-port synchronous RAM, read-first, with a registered read.
// ----------------------------------------------------------------------------
module qphi_ram #(
    parameter int WIDTH = qphi_pkg::KEY_BITS,
    parameter int DEPTH = qphi_pkg::TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/qphi_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphi_mod
// Restoring remainder unit: one dividend bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module qphi_mod #(
    parameter int DIVIDEND_W = qphi_pkg::KEY_W,
    parameter int DIVISOR_W  = qphi_pkg::SIZE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam int CW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CW-1:0] LAST = CW'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W-1:0]  n_rem;

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[DIVIDEND_W-1]};
        if (w_shift >= {1'b0, r_dsr}) begin
            n_rem = DIVISOR_W'(w_shift - {1'b0, r_dsr});
        end else begin
            n_rem = w_shift[DIVISOR_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/quadratic_probe_hash_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert
// Open-addressed hash table with quadratic probing, held in block RAM.
// ----------------------------------------------------------------------------
// One item at a time. After reset the occupancy RAM is swept clear, one slot
// a cycle, with the input not ready; config writes are taken throughout. A
// read passes through the RAM read register and the result registers to the
// output register. An insert first runs the bit-serial remainder unit, one
// key bit per cycle, and takes the home slot from it, then checks the home
// slot, then each further probe in turn, since each probe is one read of the
// single-port table RAM. Its result reports the home slot when that is free,
// the probed slot when the key lands at probe step j, and a drop once every
// step up to the effective size less one has found its slot occupied. The
// input is ready again as soon as the result is loaded into the output
// register, even while it waits there.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_insert #(
    parameter int TABLE_DEPTH = qphi_pkg::TABLE_DEPTH,
    parameter int KEY_BITS    = qphi_pkg::KEY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qphi_pkg::SIZE_W-1:0]   i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [qphi_pkg::KEY_W-1:0]    i_key,
    input  logic [qphi_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic                          i_last_in_batch,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qphi_pkg::SLOT_W-1:0]   o_slot,
    output logic [qphi_pkg::KEY_W-1:0]    o_stored_key,
    output logic                          o_occupied,
    output logic [1:0]                    o_status,
    output logic [qphi_pkg::PROBE_W-1:0]  o_probes,
    output logic                          o_batch_done
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = qphi_pkg::KEY_W;
    localparam int SW = qphi_pkg::SIZE_W;
    localparam int PW = qphi_pkg::PROBE_W;
    localparam logic [KW-1:0] KEY_MASK =
        (KEY_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

    qphi_pkg::t_state  r_state, n_state;

    logic [SW-1:0]       r_size;
    logic [AW-1:0]       r_clr;
    logic [SW-1:0]       w_n_eff;
    logic                w_in_xfer;
    logic                w_out_free;

    // item context
    logic [KW-1:0]                r_key;
    logic                         r_last;
    logic [SW-1:0]                r_n;
    logic [qphi_pkg::SLOT_W-1:0]  r_slot_idx;
    logic                         r_in_range;
    logic [SW-1:0]                r_home;
    logic [SW-1:0]                r_t;
    logic [SW-1:0]                r_d;
    logic [SW-1:0]                r_j;
    logic [KW-1:0]                r_home_key;

    // finished result
    logic [SW-1:0]                r_res_slot;
    logic [KW-1:0]                r_res_key;
    logic                         r_res_occ;
    qphi_pkg::t_status            r_res_status;
    logic [PW-1:0]                r_res_probes;

    // output register
    logic                         r_o_valid;
    logic [qphi_pkg::SLOT_W-1:0]  r_o_slot;
    logic [KW-1:0]                r_o_key;
    logic                         r_o_occ;
    qphi_pkg::t_status            r_o_status;
    logic [PW-1:0]                r_o_probes;
    logic                         r_o_last;

    // table RAM ports
    logic                 w_we;
    logic                 w_vld_wdata;
    logic [AW-1:0]        w_addr;
    logic                 w_vld_rd;
    logic [KEY_BITS-1:0]  w_key_rd;

    // remainder unit
    logic                 w_mod_start;
    logic                 w_mod_done;
    logic [SW-1:0]        w_mod_rem;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= qphi_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    // effective modulus: zero acts as one, clipped to the depth
    always_comb begin
        if (r_size == '0) begin
            w_n_eff = SW'(1);
        end else if (32'(r_size) > TABLE_DEPTH) begin
            w_n_eff = SW'(TABLE_DEPTH);
        end else begin
            w_n_eff = r_size;
        end
    end

    assign o_ready     = (r_state == qphi_pkg::S_IDLE);
    assign w_in_xfer   = i_valid && o_ready;
    assign w_out_free  = !r_o_valid || i_ready;
    assign w_mod_start = w_in_xfer && (i_func == qphi_pkg::FUNC_INSERT);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qphi_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and RAM control
    always_comb begin
        n_state     = r_state;
        w_we        = 1'b0;
        w_vld_wdata = 1'b1;
        w_addr      = AW'(r_t);
        case (r_state)
            qphi_pkg::S_CLR: begin
                w_we        = 1'b1;
                w_vld_wdata = 1'b0;
                w_addr      = r_clr;
                if (r_clr == CLR_LAST) begin
                    n_state = qphi_pkg::S_IDLE;
                end
            end
            qphi_pkg::S_IDLE: begin
                w_addr = AW'(i_slot_index);
                if (w_in_xfer) begin
                    n_state = (i_func == qphi_pkg::FUNC_READ) ? qphi_pkg::S_RDATA
                                                               : qphi_pkg::S_MOD;
                end
            end
            qphi_pkg::S_MOD: begin
                w_addr = AW'(w_mod_rem);
                if (w_mod_done) begin
                    n_state = qphi_pkg::S_HCHK;
                end
            end
            qphi_pkg::S_HCHK: begin
                if (!w_vld_rd) begin
                    w_we    = 1'b1;
                    w_addr  = AW'(r_home);
                    n_state = qphi_pkg::S_EMIT;
                end else if (r_n == SW'(1)) begin
                    n_state = qphi_pkg::S_EMIT;
                end else begin
                    w_addr  = AW'(qphi_pkg::mod_add(r_home, SW'(1), r_n));
                    n_state = qphi_pkg::S_PCHK;
                end
            end
            qphi_pkg::S_PCHK: begin
                if (!w_vld_rd) begin
                    w_we    = 1'b1;
                    w_addr  = AW'(r_t);
                    n_state = qphi_pkg::S_EMIT;
                end else if (r_j == r_n - SW'(1)) begin
                    n_state = qphi_pkg::S_EMIT;
                end else begin
                    w_addr = AW'(qphi_pkg::mod_add(r_t, r_d, r_n));
                end
            end
            qphi_pkg::S_RDATA: begin
                n_state = qphi_pkg::S_EMIT;
            end
            qphi_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = qphi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qphi_pkg::S_IDLE;
            end
        endcase
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == qphi_pkg::S_CLR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            qphi_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    r_key      <= i_key & KEY_MASK;
                    r_last     <= i_last_in_batch;
                    r_n        <= w_n_eff;
                    r_slot_idx <= i_slot_index;
                    r_in_range <= (32'(i_slot_index) < TABLE_DEPTH);
                end
            end
            qphi_pkg::S_MOD: begin
                r_home <= w_mod_rem;
            end
            qphi_pkg::S_RDATA: begin
                r_res_slot   <= SW'(r_slot_idx);
                r_res_occ    <= w_vld_rd && r_in_range;
                r_res_key    <= (w_vld_rd && r_in_range) ? KW'(w_key_rd) : '0;
                r_res_status <= qphi_pkg::ST_READ;
                r_res_probes <= '0;
            end
            qphi_pkg::S_HCHK: begin
                r_home_key <= KW'(w_key_rd);
                r_res_slot <= r_home;
                r_res_occ  <= 1'b1;
                if (!w_vld_rd) begin
                    r_res_key    <= r_key;
                    r_res_status <= qphi_pkg::ST_HOME;
                    r_res_probes <= PW'(1);
                end else begin
                    // only used when a size of one drops the key right here
                    r_res_key    <= KW'(w_key_rd);
                    r_res_status <= qphi_pkg::ST_DROPPED;
                    r_res_probes <= PW'(r_n + SW'(1));
                end
                // first probe is home + 1, step increments 3, 5, 7 ...
                r_t <= qphi_pkg::mod_add(r_home, SW'(1), r_n);
                r_d <= qphi_pkg::mod_add(SW'(1), SW'(2), r_n);
                r_j <= SW'(1);
            end
            qphi_pkg::S_PCHK: begin
                r_res_occ <= 1'b1;
                if (!w_vld_rd) begin
                    r_res_slot   <= r_t;
                    r_res_key    <= r_key;
                    r_res_status <= qphi_pkg::ST_PROBED;
                    r_res_probes <= PW'(r_j + SW'(2));
                end else if (r_j == r_n - SW'(1)) begin
                    r_res_slot   <= r_home;
                    r_res_key    <= r_home_key;
                    r_res_status <= qphi_pkg::ST_DROPPED;
                    r_res_probes <= PW'(r_n + SW'(1));
                end else begin
                    r_t <= qphi_pkg::mod_add(r_t, r_d, r_n);
                    r_d <= qphi_pkg::mod_add(r_d, SW'(2), r_n);
                    r_j <= r_j + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == qphi_pkg::S_EMIT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == qphi_pkg::S_EMIT && w_out_free) begin
            r_o_slot   <= qphi_pkg::SLOT_W'(r_res_slot);
            r_o_key    <= r_res_key;
            r_o_occ    <= r_res_occ;
            r_o_status <= r_res_status;
            r_o_probes <= r_res_probes;
            r_o_last   <= r_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_slot       = r_o_slot;
    assign o_stored_key = r_o_key;
    assign o_occupied   = r_o_occ;
    assign o_status     = r_o_status;
    assign o_probes     = r_o_probes;
    assign o_batch_done = r_o_last;

    // home slot remainder
    qphi_mod #(
        .DIVIDEND_W (KW),
        .DIVISOR_W  (SW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_key & KEY_MASK),
        .i_divisor  (w_n_eff),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // occupancy bits, cleared by the sweep
    qphi_ram #(
        .WIDTH   (1),
        .DEPTH   (TABLE_DEPTH)
    ) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_vld_wdata),
        .o_rdata (w_vld_rd)
    );

    // stored keys, written only on insert
    qphi_ram #(
        .WIDTH   (KEY_BITS),
        .DEPTH   (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && (r_state != qphi_pkg::S_CLR)),
        .i_addr  (w_addr),
        .i_wdata (KEY_BITS'(r_key)),
        .o_rdata (w_key_rd)
    );

    // an insert only ever lands on a slot just seen empty
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state != qphi_pkg::S_CLR) |-> !w_vld_rd)
        else $error("insert write to an occupied slot");

    // remainder completes only while the sequencer waits for it
    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == qphi_pkg::S_MOD))
        else $error("remainder done outside wait state");

    // probe position and step stay inside the modulus
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qphi_pkg::S_PCHK) |->
            (r_t < r_n && r_d < r_n && r_j != '0 && r_j < r_n))
        else $error("probe state out of range");

    // a result is presented once the output register is free
    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qphi_pkg::S_EMIT && w_out_free) |=>
            (o_valid && r_state == qphi_pkg::S_IDLE))
        else $error("result not loaded");

    // no item is taken before the clear sweep ends
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qphi_pkg::S_CLR) |-> (!o_ready && !w_mod_start))
        else $error("item accepted during clear sweep");

endmodule
